### sv/mtds_pkg.sv
// ----------------------------------------------------------------------------
// mtds_pkg
// shared constants of the tds meter
// ----------------------------------------------------------------------------
package mtds_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_VREF = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TEMP = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LIMIT = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_BATCH = 2'd3;

  localparam logic [1:0] ALERT_NONE = 2'd0;
  localparam logic [1:0] ALERT_OVER = 2'd1;
  localparam logic [1:0] ALERT_ZERO = 2'd2;

  localparam logic [18:0] VoltMax = 19'h7FFFF;
  localparam logic [17:0] CoefCube = 18'd34156;
  localparam logic [17:0] CoefSquare = 18'd65500;
  localparam logic [17:0] CoefLinear = 18'd219492;

  // ceil(2^33 / 125): exact floor division by 125 for numerators below 2^26
  localparam logic [26:0] Recip125 = 27'd68719477;

endpackage

### sv/median_tds_meter.sv
// ----------------------------------------------------------------------------
// median_tds_meter
// tds probe meter: window median, compensation, cubic, batch alerts
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid, in_stall, adc_sample
// out     | output    | out_valid, out_stall, tds_ppm .. alert_code
// cfg     | input     | cfg_we, cfg_index, cfg_data
// the median is a rank count over the window, one compare per cycle, followed
// by the conversion on one multiplier and a 25-step divider
// in_stall falls in the same cycle in which the result appears in the output
// register; a held result only stalls the next result, not the next input
// reset clears the window through valid bits, no clearing pass
// ----------------------------------------------------------------------------
module median_tds_meter #(
  parameter int unsigned WINDOW_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  adc_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] tds_ppm,
  output logic        over_limit,
  output logic        zero_reading,
  output logic        batch_end,
  output logic [1:0]  alert_code,
  input  logic        cfg_we,
  input  logic [mtds_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mtds_pkg::CfgDataW-1:0] cfg_data
);

  localparam int unsigned IdxW = $clog2(WINDOW_SIZE);
  localparam int unsigned CntW = $clog2(WINDOW_SIZE + 1);
  localparam logic [CntW-1:0] RankLo = CntW'((WINDOW_SIZE - 1) / 2);
  localparam logic [CntW-1:0] RankHi = CntW'(WINDOW_SIZE / 2);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW_SIZE - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RANK = 5'b00010,
    S_CONV = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  logic [12:0] vref_mv;
  logic [6:0]  temperature_c;
  logic [15:0] ppm_threshold;
  logic [7:0]  batch_length;
  logic [9:0]  win [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] wvalid;
  logic [IdxW-1:0] write_slot, ci, cj;
  logic [CntW-1:0] less_cnt, eq_cnt;
  logic [9:0] lo_val, hi_val, cand, other;
  logic [7:0] batch_position, over_count, zero_count;
  logic conv_start, conv_done;
  logic [15:0] tds;
  logic [10:0] msum;
  logic over, zero, fin;
  logic [7:0] len, pos_n;

  assign cand = wvalid[ci] ? win[ci] : 10'd0;
  assign other = wvalid[cj] ? win[cj] : 10'd0;
  assign msum = {1'b0, lo_val} + {1'b0, hi_val};
  assign in_stall = (state != S_IDLE);
  assign over = tds > ppm_threshold;
  assign zero = !over && (tds == 16'd0);
  assign len = (batch_length == 8'd0) ? 8'd1 : batch_length;
  assign pos_n = batch_position + 8'd1;
  assign fin = pos_n >= len;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      vref_mv <= 13'd5000;
      temperature_c <= 7'd25;
      ppm_threshold <= 16'd1000;
      batch_length <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        mtds_pkg::REG_VREF:  vref_mv <= cfg_data[12:0];
        mtds_pkg::REG_TEMP:  temperature_c <= cfg_data[6:0];
        mtds_pkg::REG_LIMIT: ppm_threshold <= cfg_data;
        mtds_pkg::REG_BATCH: batch_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // window storage
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) win[write_slot] <= adc_sample;
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wvalid <= '0;
      write_slot <= '0;
      batch_position <= '0;
      over_count <= '0;
      zero_count <= '0;
      out_valid <= 1'b0;
      conv_start <= 1'b0;
    end else begin
      conv_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            wvalid[write_slot] <= 1'b1;
            write_slot <= (write_slot == LastIdx) ? '0 : write_slot + 1'b1;
            ci <= '0;
            cj <= '0;
            less_cnt <= '0;
            eq_cnt <= '0;
            state <= S_RANK;
          end
        end
        S_RANK: begin
          // rank count of candidate ci against element cj
          logic [CntW-1:0] l2, e2;
          l2 = less_cnt + ((other < cand) ? CntW'(1) : CntW'(0));
          e2 = eq_cnt + ((other == cand) ? CntW'(1) : CntW'(0));
          if (cj == LastIdx) begin
            if (l2 <= RankLo && RankLo < l2 + e2) lo_val <= cand;
            if (l2 <= RankHi && RankHi < l2 + e2) hi_val <= cand;
            less_cnt <= '0;
            eq_cnt <= '0;
            cj <= '0;
            if (ci == LastIdx) begin
              state <= S_CONV;
            end else begin
              ci <= ci + 1'b1;
            end
          end else begin
            less_cnt <= l2;
            eq_cnt <= e2;
            cj <= cj + 1'b1;
          end
        end
        S_CONV: begin
          conv_start <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (conv_done) state <= S_OUT;
        end
        S_OUT: begin
          // load the output register once it is free
          if (!out_valid || !out_stall) begin
            tds_ppm <= tds;
            over_limit <= over;
            zero_reading <= zero;
            batch_end <= fin;
            alert_code <= mtds_pkg::ALERT_NONE;
            if (fin) begin
              if (over_count + {7'd0, over} == pos_n) alert_code <= mtds_pkg::ALERT_OVER;
              else if (zero_count + {7'd0, zero} == pos_n)
                alert_code <= mtds_pkg::ALERT_ZERO;
              batch_position <= '0;
              over_count <= '0;
              zero_count <= '0;
            end else begin
              batch_position <= pos_n;
              over_count <= over_count + {7'd0, over};
              zero_count <= zero_count + {7'd0, zero};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // output register valid
      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  mtds_conv u_conv (
    .clk(clk),
    .rst(rst),
    .start(conv_start),
    .median(msum[10:1]),
    .vref_mv(vref_mv),
    .temperature_c(temperature_c),
    .done(conv_done),
    .tds(tds)
  );

endmodule

### sv/mtds_conv.sv
// ----------------------------------------------------------------------------
// mtds_conv
// median to tds conversion on one shared multiplier and a serial divider
// ----------------------------------------------------------------------------
module mtds_conv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [9:0]  median,
  input  logic [12:0] vref_mv,
  input  logic [6:0]  temperature_c,
  output logic        done,
  output logic [15:0] tds
);

  typedef enum logic [10:0] {
    C_IDLE = 11'b00000000001,
    C_MY   = 11'b00000000010,
    C_MR   = 11'b00000000100,
    C_M50  = 11'b00000001000,
    C_DIV  = 11'b00000010000,
    C_SQ   = 11'b00000100000,
    C_CU   = 11'b00001000000,
    C_P1   = 11'b00010000000,
    C_P2   = 11'b00100000000,
    C_P3   = 11'b01000000000,
    C_FIN  = 11'b10000000000
  } cstate_t;

  cstate_t state;
  logic [4:0]  cnt;
  logic [26:0] mul_a, mul_b;
  logic [53:0] prod;
  logic [22:0] y;
  logic [19:0] v;
  logic [18:0] vsat, vc;
  logic [24:0] num;
  logic [7:0]  rem, dvs;
  logic [8:0]  rem_sh, rem_sub;
  logic [21:0] v2;
  logic [24:0] v3;
  logic signed [43:0] acc;

  // volts saturate at q3.16 max, compensated volts likewise
  assign vsat = v[19] ? mtds_pkg::VoltMax : v[18:0];
  assign vc = (|num[24:19]) ? mtds_pkg::VoltMax : num[18:0];
  assign dvs = {1'b0, temperature_c} + 8'd25;
  assign rem_sh = {rem, num[24]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      C_MY: begin
        mul_a = {17'd0, median};
        mul_b = {14'd0, vref_mv};
      end
      C_MR: begin
        // m*vref*64/1000 is m*vref*8/125
        mul_a = {1'b0, y, 3'd0};
        mul_b = mtds_pkg::Recip125;
      end
      C_M50: begin
        mul_a = {8'd0, vsat};
        mul_b = 27'd50;
      end
      C_SQ: begin
        mul_a = {8'd0, vc};
        mul_b = {8'd0, vc};
      end
      C_CU: begin
        mul_a = {5'd0, v2};
        mul_b = {8'd0, vc};
      end
      C_P1: begin
        mul_a = {2'd0, v3};
        mul_b = {9'd0, mtds_pkg::CoefCube};
      end
      C_P2: begin
        mul_a = {5'd0, v2};
        mul_b = {9'd0, mtds_pkg::CoefSquare};
      end
      C_P3: begin
        mul_a = {8'd0, vc};
        mul_b = {9'd0, mtds_pkg::CoefLinear};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) state <= C_MY;
        end
        C_MY: begin
          y <= prod[22:0];
          state <= C_MR;
        end
        C_MR: begin
          v <= prod[52:33];
          state <= C_M50;
        end
        C_M50: begin
          // v*50 over (t+25), restoring divider one quotient bit per cycle
          num <= prod[24:0];
          rem <= '0;
          cnt <= 5'd24;
          state <= C_DIV;
        end
        C_DIV: begin
          if (!rem_sub[8]) begin
            rem <= rem_sub[7:0];
            num <= {num[23:0], 1'b1};
          end else begin
            rem <= rem_sh[7:0];
            num <= {num[23:0], 1'b0};
          end
          if (cnt == 5'd0) state <= C_SQ;
          else cnt <= cnt - 5'd1;
        end
        C_SQ: begin
          v2 <= prod[37:16];
          state <= C_CU;
        end
        C_CU: begin
          v3 <= prod[40:16];
          state <= C_P1;
        end
        C_P1: begin
          acc <= $signed({1'b0, prod[42:0]});
          state <= C_P2;
        end
        C_P2: begin
          acc <= acc - $signed({1'b0, prod[42:0]});
          state <= C_P3;
        end
        C_P3: begin
          acc <= acc + $signed({1'b0, prod[42:0]});
          state <= C_FIN;
        end
        C_FIN: begin
          // clamp negative, halve the q24 value, saturate at 16 bits
          if (acc[43]) tds <= '0;
          else if (|acc[42:41]) tds <= 16'hFFFF;
          else tds <= acc[40:25];
          done <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### sv/median_tds_meter_check.sv
// ----------------------------------------------------------------------------
// median_tds_meter_check
// port level checks of the tds meter
// ----------------------------------------------------------------------------
module median_tds_meter_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        over_limit,
  input logic        zero_reading,
  input logic        batch_end,
  input logic [1:0]  alert_code
);

  // a held result keeps its valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

  // classes exclude each other
  a_cls: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(over_limit && zero_reading)) else $error("both classes");

  // alert only at batch end
  a_alert: assert property (@(posedge clk) disable iff (rst)
    out_valid && !batch_end |-> alert_code == mtds_pkg::ALERT_NONE)
    else $error("stray alert");

  // an accepted transaction makes the input busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("accepted while busy");

endmodule

bind median_tds_meter median_tds_meter_check u_check (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .over_limit(over_limit),
  .zero_reading(zero_reading), .batch_end(batch_end), .alert_code(alert_code)
);
